// ----- src/ohfc_pkg.sv -----
// shared types and constants for the open-handle fifo cache
// used by ohfc_ctrl, ohfc_datapath and open_handle_fifo_cache; no dependencies
package ohfc_pkg;

    localparam int MAX_CACHE_ENTRIES_DEF = 16;
    localparam int NUM_FILES_DEF         = 64;
    localparam int DEFAULT_CAPACITY_DEF  = 8;

    localparam int CMD_W       = 2;
    localparam int ENTRY_W     = 6;
    localparam int REQ_W       = 5;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_OPEN   = 2'd0,
        CMD_CLOSE  = 2'd1,
        CMD_RESIZE = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_EVICT,
        ST_INSERT,
        ST_REMOVE,
        ST_FINAL
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic search;
        logic evict;
        logic insert;
        logic remove;
        logic finish;
    } t_dp_ctrl;

    // datapath to controller
    typedef struct packed {
        logic evict_req;
        logic do_open;
        logic do_close;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- src/ohfc_ctrl.sv -----
// command sequencer for the open-handle fifo cache
// depends on ohfc_pkg; drives ohfc_datapath through t_dp_ctrl
module ohfc_ctrl import ohfc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (i_stat.evict_req) begin
                    n_state = ST_EVICT;
                end else if (i_stat.do_open) begin
                    n_state = ST_INSERT;
                end else if (i_stat.do_close) begin
                    n_state = ST_REMOVE;
                end else begin
                    n_state = ST_FINAL;
                end
            end
            ST_EVICT: begin
                if (i_stat.out_free) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_INSERT: n_state = ST_FINAL;
            ST_REMOVE: n_state = ST_FINAL;
            ST_FINAL: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.take = i_in_valid;
            end
            ST_SEARCH: o_ctrl.search = 1'b1;
            ST_EVICT:  o_ctrl.evict  = i_stat.out_free;
            ST_INSERT: o_ctrl.insert = 1'b1;
            ST_REMOVE: o_ctrl.remove = 1'b1;
            ST_FINAL:  o_ctrl.finish = i_stat.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/ohfc_datapath.sv -----
// order list, count, capacity and result register of the open-handle fifo cache
// depends on ohfc_pkg; sequenced by ohfc_ctrl
module ohfc_datapath import ohfc_pkg::*; #(
    parameter int MAX_CACHE_ENTRIES = MAX_CACHE_ENTRIES_DEF,
    parameter int NUM_FILES         = NUM_FILES_DEF,
    parameter int DEFAULT_CAPACITY  = DEFAULT_CAPACITY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_ctrl               i_ctrl,
    output t_dp_stat               o_stat,
    input  logic [CMD_W-1:0]       i_command,
    input  logic [ENTRY_W-1:0]     i_entry_id,
    input  logic [REQ_W-1:0]       i_new_capacity,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_event_res,
    output logic [ENTRY_W-1:0]     o_result_entry,
    output logic                   o_already_open,
    output logic [COUNT_OUT_W-1:0] o_open_count,
    output logic                   o_last_result
);

    localparam int CNT_W = $clog2(MAX_CACHE_ENTRIES + 1);
    localparam int IDX_W = $clog2(MAX_CACHE_ENTRIES);
    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(MAX_CACHE_ENTRIES);
    localparam int CAP_RST_I = (DEFAULT_CAPACITY < 1) ? 1 :
                               (DEFAULT_CAPACITY > MAX_CACHE_ENTRIES) ? MAX_CACHE_ENTRIES :
                               DEFAULT_CAPACITY;
    localparam logic [CNT_W-1:0] CAP_RST = CNT_W'(CAP_RST_I);
    localparam logic [MAX_CACHE_ENTRIES-1:0] LSB_ONE = {{(MAX_CACHE_ENTRIES-1){1'b0}}, 1'b1};

    logic [ENTRY_W-1:0]           r_list [MAX_CACHE_ENTRIES];
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             r_capacity;
    t_cmd                         r_cmd;
    logic [ENTRY_W-1:0]           r_id;
    logic [CNT_W-1:0]             r_req;
    logic                         r_was_open;
    logic [MAX_CACHE_ENTRIES-1:0] r_shift_mask;

    logic                         r_out_valid;
    logic                         r_out_ev;
    logic [ENTRY_W-1:0]           r_out_entry;
    logic                         r_out_open;
    logic [CNT_W-1:0]             r_out_count;
    logic                         r_out_last;

    logic [CNT_W-1:0]             req_sat;
    logic [MAX_CACHE_ENTRIES-1:0] match;
    logic                         in_range;
    logic [CNT_W-1:0]             cnt_dec;
    logic [IDX_W-1:0]             tail_idx;
    logic                         room;

    always_comb begin
        if (i_new_capacity == '0) begin
            req_sat = CNT_W'(1);
        end else if (32'(i_new_capacity) > MAX_CACHE_ENTRIES) begin
            req_sat = CAP_MAX;
        end else begin
            req_sat = CNT_W'(i_new_capacity);
        end
    end

    // only slots below the count hold live entries
    always_comb begin
        for (int i = 0; i < MAX_CACHE_ENTRIES; i++) begin
            match[i] = (r_list[i] == r_id) && (CNT_W'(i) < r_count);
        end
    end

    assign in_range = 32'(r_id) < NUM_FILES;
    assign cnt_dec  = r_count - CNT_W'(1);
    assign tail_idx = cnt_dec[IDX_W-1:0];
    assign room     = r_count < CAP_MAX;

    assign o_stat.do_open   = (r_cmd == CMD_OPEN) && in_range && !r_was_open;
    assign o_stat.do_close  = (r_cmd == CMD_CLOSE) && r_was_open;
    assign o_stat.evict_req = (r_cmd == CMD_RESIZE) ? (r_count > r_req) :
                              (o_stat.do_open && (r_count != '0) && (r_count >= r_capacity));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_cmd <= t_cmd'(i_command);
            r_id  <= i_entry_id;
            r_req <= req_sat;
        end
        if (i_ctrl.search) begin
            r_was_open   <= (|match) && in_range &&
                            ((r_cmd == CMD_OPEN) || (r_cmd == CMD_CLOSE));
            // bits at and above the matching slot shift toward the head
            r_shift_mask <= ~(match - LSB_ONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert && room) begin
            r_list[0] <= r_id;
            for (int i = 1; i < MAX_CACHE_ENTRIES; i++) begin
                r_list[i] <= r_list[i-1];
            end
        end else if (i_ctrl.remove) begin
            for (int i = 0; i < MAX_CACHE_ENTRIES - 1; i++) begin
                if (r_shift_mask[i]) begin
                    r_list[i] <= r_list[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_capacity <= CAP_RST;
        end else begin
            if (i_ctrl.evict || i_ctrl.remove) begin
                r_count <= cnt_dec;
            end else if (i_ctrl.insert && room) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_ctrl.finish && (r_cmd == CMD_RESIZE)) begin
                r_capacity <= r_req;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.evict || i_ctrl.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.evict) begin
            r_out_ev    <= 1'b1;
            r_out_entry <= r_list[tail_idx];
            r_out_open  <= 1'b1;
            r_out_count <= cnt_dec;
            r_out_last  <= 1'b0;
        end else if (i_ctrl.finish) begin
            r_out_ev    <= 1'b0;
            r_out_entry <= (r_cmd == CMD_RESIZE) ? '0 : r_id;
            r_out_open  <= r_was_open;
            r_out_count <= r_count;
            r_out_last  <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_out_ev;
    assign o_result_entry = r_out_entry;
    assign o_already_open = r_out_open;
    assign o_open_count   = COUNT_OUT_W'(r_out_count);
    assign o_last_result  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_MAX)
        else $error("open count above list depth");

    a_cap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_capacity != '0) && (r_capacity <= CAP_MAX))
        else $error("capacity out of range");

    a_evict_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.evict |-> (r_count != '0))
        else $error("eviction from an empty list");

    a_insert_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.insert |-> (r_count < r_capacity))
        else $error("insert with the list at capacity");

endmodule

// ----- src/open_handle_fifo_cache.sv -----
// after the input transfer the search and decide states run; an open or close
// that changes the list then passes an insert or remove state, and each evicted entry
// passes the evict state and returns to decide (one eviction per result); the done
// result is registered in the final state. One command at a time, held by output
// stalls; the next command is taken while the done result waits downstream
// reset: count zero, capacity the saturated default; list slots are not cleared
module open_handle_fifo_cache import ohfc_pkg::*; #(
    parameter int MAX_CACHE_ENTRIES = MAX_CACHE_ENTRIES_DEF,
    parameter int NUM_FILES         = NUM_FILES_DEF,
    parameter int DEFAULT_CAPACITY  = DEFAULT_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // entry_id[5:0], new_capacity[10:6], zero pad
    input  logic [1:0]  i_s_axis_tuser,   // command[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // result_entry[5:0], already_open[6],
                                          // open_count[11:7], zero pad
    output logic [0:0]  o_m_axis_tuser,   // event_res[0]
    output logic        o_m_axis_tlast    // last_result
);

    t_dp_ctrl               ctrl;
    t_dp_stat               stat;
    logic [ENTRY_W-1:0]     result_entry;
    logic                   already_open;
    logic [COUNT_OUT_W-1:0] open_count;
    logic                   event_res;

    ohfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    ohfc_datapath #(
        .MAX_CACHE_ENTRIES (MAX_CACHE_ENTRIES),
        .NUM_FILES         (NUM_FILES),
        .DEFAULT_CAPACITY  (DEFAULT_CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .o_stat         (stat),
        .i_command      (i_s_axis_tuser),
        .i_entry_id     (i_s_axis_tdata[5:0]),
        .i_new_capacity (i_s_axis_tdata[10:6]),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_event_res    (event_res),
        .o_result_entry (result_entry),
        .o_already_open (already_open),
        .o_open_count   (open_count),
        .o_last_result  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'b0000, open_count, already_open, result_entry};
    assign o_m_axis_tuser = event_res;

endmodule
